/* hw/rtl/tpq_pkg.sv */
package tpq_pkg;

    // Ring of frame slots (default depth) and the largest frame in bytes
    localparam int QUEUE_SLOTS_DEF = 128;
    localparam int MAX_PACKET      = 128;

    // Depth of the queue between the front and the back, a power of two
    localparam int FIFO_DEPTH = 4;

    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;

    // Command codes
    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_DONE = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_STORE = 2'd0;
    localparam logic [1:0] KIND_SEND  = 2'd1;
    localparam logic [1:0] KIND_DROP  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BREAK_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEEPALIVE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PKT_SIZE   = 2'd2;

    localparam logic [15:0] BREAK_TIME_RST = 16'd15;
    localparam logic [19:0] KEEPALIVE_RST  = 20'd500000;
    localparam logic [7:0]  PKT_SIZE_RST   = 8'd100;

    localparam logic [19:0] QUIET_MAX = 20'hFFFFF;

    // Everything one input item produces: an optional store beat followed
    // by an optional send request or drop notice.
    typedef struct packed {
        logic       has_store;
        logic [6:0] st_slot;
        logic [6:0] st_offset;
        logic [7:0] st_byte;
        logic       has_ev;
        logic [1:0] ev_kind;
        logic [6:0] ev_slot;
        logic [7:0] ev_len;
    } t_rec;

endpackage

/* hw/rtl/tpq_ram.sv */
module tpq_ram
    import tpq_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/tpq_fifo.sv */
module tpq_fifo
    import tpq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    output logic o_full,
    input  logic i_pop,
    output t_rec o_rec,
    output logic o_empty
);

    localparam int AW = $clog2(FIFO_DEPTH);

    t_rec          r_buf [FIFO_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == (AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            // pointers wrap on their own, the depth being a power of two
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr] <= i_rec;
        end
    end

endmodule

/* hw/rtl/tpq_front.sv */
module tpq_front
    import tpq_pkg::*;
#(
    parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  logic [1:0]            i_cmd,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_send_ok,
    output logic                  o_rec_push,
    output t_rec                  o_rec
);

    localparam int IDX_W = $clog2(QUEUE_SLOTS);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(QUEUE_SLOTS - 1);

    logic [15:0]      r_break;
    logic [19:0]      r_keep;
    logic [7:0]       r_psize;

    logic [IDX_W-1:0] r_ws, n_ws;
    logic [IDX_W-1:0] r_rs, n_rs;
    logic [IDX_W-1:0] r_queued, n_queued;
    logic [7:0]       r_fill, n_fill;
    logic [19:0]      r_quiet, n_quiet;
    logic             r_sending, n_sending;
    logic [7:0]       r_head_len, n_head_len;
    logic             r_byp_hit;
    logic [7:0]       r_byp_data;

    logic [7:0]       eff_size;
    logic [7:0]       fill_inc;
    logic [19:0]      quiet_inc;
    logic             commit;
    logic [7:0]       commit_len;
    logic [IDX_W-1:0] ws_next;
    logic [IDX_W-1:0] rs_next;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       mem_rdata;
    logic [7:0]       next_len;
    logic             wr_en;
    t_rec             rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_break <= BREAK_TIME_RST;
            r_keep  <= KEEPALIVE_RST;
            r_psize <= PKT_SIZE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BREAK_TIME: r_break <= i_cfg_data[15:0];
                REG_KEEPALIVE:  r_keep  <= i_cfg_data[19:0];
                REG_PKT_SIZE:   r_psize <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_psize == 8'd0) begin
            eff_size = 8'd1;
        end else if (r_psize > 8'(MAX_PACKET)) begin
            eff_size = 8'(MAX_PACKET);
        end else begin
            eff_size = r_psize;
        end
    end

    assign ws_next   = (r_ws == LAST_SLOT) ? '0 : r_ws + 1'b1;
    assign rs_next   = (r_rs == LAST_SLOT) ? '0 : r_rs + 1'b1;
    assign fill_inc  = r_fill + 8'd1;
    assign quiet_inc = (r_quiet == QUIET_MAX) ? r_quiet : r_quiet + 20'd1;

    // Length of the frame behind the head; the RAM read was issued in the
    // previous cycle, and a write to the same slot in that cycle is forwarded.
    assign next_len = r_byp_hit ? r_byp_data : mem_rdata;

    always_comb begin
        n_ws       = r_ws;
        n_rs       = r_rs;
        n_queued   = r_queued;
        n_fill     = r_fill;
        n_quiet    = r_quiet;
        n_sending  = r_sending;
        n_head_len = r_head_len;
        commit     = 1'b0;
        commit_len = '0;
        wr_en      = 1'b0;
        rec        = '0;

        if (i_accept) begin
            case (i_cmd)
                CMD_BYTE: begin
                    rec.has_store = 1'b1;
                    rec.st_slot   = 7'(r_ws);
                    rec.st_offset = r_fill[6:0];
                    rec.st_byte   = i_data_byte;
                    n_fill        = fill_inc;
                    n_quiet       = '0;
                    if (fill_inc >= eff_size) begin
                        commit     = 1'b1;
                        commit_len = fill_inc;
                    end
                end
                CMD_TICK: begin
                    n_quiet = quiet_inc;
                    if (r_fill != 8'd0) begin
                        if (quiet_inc > {4'd0, r_break}) begin
                            commit     = 1'b1;
                            commit_len = r_fill;
                        end
                    end else if (!r_sending && quiet_inc >= r_keep) begin
                        // keepalive frame
                        commit     = 1'b1;
                        commit_len = eff_size + 8'd1;
                    end
                end
                CMD_DONE: begin
                    if (r_sending) begin
                        if (r_queued == '0) begin
                            n_sending = 1'b0;
                        end else if (!i_send_ok) begin
                            // retry the head
                            rec.has_ev  = 1'b1;
                            rec.ev_kind = KIND_SEND;
                            rec.ev_slot = 7'(r_rs);
                            rec.ev_len  = r_head_len;
                        end else begin
                            n_rs     = rs_next;
                            n_queued = r_queued - 1'b1;
                            if (r_queued != IDX_W'(1)) begin
                                rec.has_ev  = 1'b1;
                                rec.ev_kind = KIND_SEND;
                                rec.ev_slot = 7'(rs_next);
                                rec.ev_len  = next_len;
                                n_head_len  = next_len;
                            end else begin
                                n_sending = 1'b0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        if (commit) begin
            n_fill  = '0;
            n_quiet = '0;
            if (r_queued >= LAST_SLOT) begin
                // ring full: drop the frame
                rec.has_ev  = 1'b1;
                rec.ev_kind = KIND_DROP;
                rec.ev_slot = 7'(r_ws);
                rec.ev_len  = commit_len;
            end else begin
                wr_en    = 1'b1;
                n_ws     = ws_next;
                n_queued = r_queued + 1'b1;
                if (!r_sending) begin
                    // ring was empty, so the new frame is the head
                    n_sending   = 1'b1;
                    n_head_len  = commit_len;
                    rec.has_ev  = 1'b1;
                    rec.ev_kind = KIND_SEND;
                    rec.ev_slot = 7'(r_ws);
                    rec.ev_len  = commit_len;
                end
            end
        end
    end

    assign rd_addr    = (n_rs == LAST_SLOT) ? '0 : n_rs + 1'b1;
    assign o_rec      = rec;
    assign o_rec_push = rec.has_store || rec.has_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws      <= '0;
            r_rs      <= '0;
            r_queued  <= '0;
            r_fill    <= '0;
            r_quiet   <= '0;
            r_sending <= 1'b0;
            r_byp_hit <= 1'b0;
        end else begin
            r_ws      <= n_ws;
            r_rs      <= n_rs;
            r_queued  <= n_queued;
            r_fill    <= n_fill;
            r_quiet   <= n_quiet;
            r_sending <= n_sending;
            r_byp_hit <= wr_en && (r_ws == rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_head_len <= n_head_len;
        r_byp_data <= commit_len;
    end

    tpq_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_SLOTS)
    ) u_len_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_ws),
        .i_wr_data (commit_len),
        .i_rd_addr (rd_addr),
        .o_rd_data (mem_rdata)
    );

endmodule

/* hw/rtl/tpq_back.sv */
module tpq_back
    import tpq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_rec       i_rec,
    input  logic       i_rec_empty,
    output logic       o_rec_pop,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [1:0] o_kind,
    output logic [6:0] o_slot,
    output logic [6:0] o_offset,
    output logic [7:0] o_byte_out,
    output logic [7:0] o_length,
    output logic       o_last
);

    logic r_valid;
    logic r_phase;
    t_rec r_rec;
    logic show_store;
    logic is_last;
    logic take;
    logic load;

    // phase 0 shows the store beat, phase 1 the request or drop beat
    assign show_store = !r_phase;
    assign is_last    = r_phase || !r_rec.has_ev;
    assign take       = i_pop && r_valid;
    assign load       = (!r_valid || (take && is_last)) && !i_rec_empty;
    assign o_rec_pop  = load;
    assign o_empty    = !r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_phase <= !i_rec.has_store;
        end else if (take) begin
            if (is_last) begin
                r_valid <= 1'b0;
            end else begin
                r_phase <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec <= i_rec;
        end
    end

    always_comb begin
        if (show_store) begin
            o_kind     = KIND_STORE;
            o_slot     = r_rec.st_slot;
            o_offset   = r_rec.st_offset;
            o_byte_out = r_rec.st_byte;
            o_length   = 8'd0;
        end else begin
            o_kind     = r_rec.ev_kind;
            o_slot     = r_rec.ev_slot;
            o_offset   = 7'd0;
            o_byte_out = 8'd0;
            o_length   = r_rec.ev_len;
        end
        o_last = is_last;
    end

endmodule

/* hw/rtl/timeout_packetizer_tx_queue.sv */
// Idle-timeout packetizer with a transmit ring of frame slots. Push commands
// (byte, microsecond tick, send finished) into the input queue; pop results
// from the output queue: store beats (slot, offset, byte), send requests for
// the head slot with its frame length (packet size plus one marks a
// keepalive), and drop notices when a frame closes against a full ring. Each
// command yields zero, one or two results, the last one flagged. The front
// takes one command per cycle while the queue is not full and updates all
// ring and timer state in that cycle; the back hands out one result per
// cycle, so a command that makes two results needs two pops and a
// four-entry queue between the two parts absorbs the difference. A result
// passes through that queue and a register in the back before it shows on
// the output. Frame lengths live in a QUEUE_SLOTS x 8 RAM with one
// write and one read port; it needs no clearing after reset. Configuration
// writes are always ready and must be made while the block is idle.
module timeout_packetizer_tx_queue
    import tpq_pkg::*;
#(
    parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            i_cmd,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_send_ok,
    output logic                  empty,
    input  logic                  pop,
    output logic [1:0]            o_kind,
    output logic [6:0]            o_slot,
    output logic [6:0]            o_offset,
    output logic [7:0]            o_byte_out,
    output logic [7:0]            o_length,
    output logic                  o_last
);

    logic accept;
    logic rec_push;
    t_rec rec_in;
    t_rec rec_out;
    logic rec_empty;
    logic rec_pop;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    tpq_front #(
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_cmd       (i_cmd),
        .i_data_byte (i_data_byte),
        .i_send_ok   (i_send_ok),
        .o_rec_push  (rec_push),
        .o_rec       (rec_in)
    );

    tpq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_rec   (rec_in),
        .o_full  (full),
        .i_pop   (rec_pop),
        .o_rec   (rec_out),
        .o_empty (rec_empty)
    );

    tpq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (rec_out),
        .i_rec_empty (rec_empty),
        .o_rec_pop   (rec_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_kind      (o_kind),
        .o_slot      (o_slot),
        .o_offset    (o_offset),
        .o_byte_out  (o_byte_out),
        .o_length    (o_length),
        .o_last      (o_last)
    );

endmodule
